[design/oal_pkg.sv]
package oal_pkg;

  // list geometry
  localparam int DEPTH   = 16;
  localparam int ENTRY_W = 32;
  localparam int POS_W   = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [2:0] OP_INSERT   = 3'd0;
  localparam logic [2:0] OP_APPEND   = 3'd1;
  localparam logic [2:0] OP_DEL_POS  = 3'd2;
  localparam logic [2:0] OP_DEL_VAL  = 3'd3;
  localparam logic [2:0] OP_FIND_MAX = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADPOS   = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]                op;
    logic [POS_W-1:0]          position;
    logic signed [ENTRY_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [POS_W-1:0]          entry_count;
    logic signed [ENTRY_W-1:0] max_value;
    logic signed [ENTRY_W-1:0] removed_value;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } dp_sts_t;

endpackage

[design/oal_ctrl.sv]
module oal_ctrl
  import oal_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // execute only once the output register is free or being emptied
  assign commit = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.step   = (state_r == S_SCAN);
    cmd.commit = commit;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/oal_datapath.sv]
module oal_datapath
  import oal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_data
);

  logic signed [ENTRY_W-1:0] entries_r [DEPTH];
  logic [CNT_W-1:0]          count_r, count_nxt;
  in_item_t                  item_r;
  logic [IDX_W-1:0]          scan_idx_r;
  logic signed [ENTRY_W-1:0] max_r;
  out_item_t                 out_r, out_nxt;

  logic signed [ENTRY_W-1:0] cur;
  logic                      hit, last;
  logic [CMP_W-1:0]          cnt_ext, pos_ext, in_pos_ext;
  logic                      full, empty;
  logic                      do_ins, do_del;
  logic [IDX_W-1:0]          ins_idx;

  assign cnt_ext    = CMP_W'(count_r);
  assign pos_ext    = CMP_W'(item_r.position);
  assign in_pos_ext = CMP_W'(in_data.position);
  assign full       = (count_r == CNT_W'(DEPTH));
  assign empty      = (count_r == '0);

  // single read port of the cells, addressed by the scan pointer
  assign cur  = entries_r[scan_idx_r];
  assign hit  = (item_r.op == OP_DEL_VAL) && (cur == item_r.operand_value);
  assign last = ((CMP_W'(scan_idx_r) + CMP_W'(1)) == cnt_ext);

  always_comb begin
    sts.need_scan = ((in_data.op == OP_DEL_VAL) || (in_data.op == OP_FIND_MAX)) && !empty;
    sts.scan_done = hit || last;
  end

  // item capture and scan over the held entries
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
      max_r  <= entries_r[0];
      if (in_data.op == OP_DEL_POS) begin
        scan_idx_r <= in_pos_ext[IDX_W-1:0];
      end else begin
        scan_idx_r <= '0;
      end
    end else if (cmd.step) begin
      if ((item_r.op == OP_FIND_MAX) && (cur > max_r)) begin
        max_r <= cur;
      end
      if (!(hit || last)) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
      end
    end
  end

  // operation decode and result
  always_comb begin
    do_ins    = 1'b0;
    do_del    = 1'b0;
    ins_idx   = pos_ext[IDX_W-1:0];
    count_nxt = count_r;
    out_nxt.status        = ST_OK;
    out_nxt.max_value     = '0;
    out_nxt.removed_value = '0;
    case (item_r.op)
      OP_INSERT: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          out_nxt.status = ST_BADPOS;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_APPEND: begin
        ins_idx = cnt_ext[IDX_W-1:0];
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_DEL_POS: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          out_nxt.status = ST_BADPOS;
        end else begin
          do_del = 1'b1;
          out_nxt.removed_value = cur;
        end
      end
      OP_DEL_VAL: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else if (cur != item_r.operand_value) begin
          out_nxt.status = ST_NOTFOUND;
        end else begin
          do_del = 1'b1;
          out_nxt.removed_value = cur;
        end
      end
      OP_FIND_MAX: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.max_value = max_r;
        end
      end
      default: ;
    endcase
    if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_del) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_nxt.entry_count = count_nxt[POS_W-1:0];
  end

  // per-cell shift: insert opens a slot, delete closes one
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ENTRY_W-1:0] below, above;
    if (g == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid
      assign below = entries_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign above = entries_r[g];
    end else begin : g_low
      assign above = entries_r[g+1];
    end
    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        if (do_ins) begin
          if (IDX_W'(g) == ins_idx) begin
            entries_r[g] <= item_r.operand_value;
          end else if (IDX_W'(g) > ins_idx) begin
            entries_r[g] <= below;
          end
        end else if (do_del && (IDX_W'(g) >= scan_idx_r)) begin
          entries_r[g] <= above;
        end
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

[design/ordered_array_list_engine_core.sv]
// Ordered list engine holding up to DEPTH signed 32-bit entries in register
// cells plus an entry count. Each input beat carries one operation and gives
// exactly one result beat. Insert, append and delete at a position capture
// the beat, then shift all cells in parallel and load the result register.
// Delete by value and find max capture the beat, then walk the cells through
// one read port, one entry a cycle, visiting up to the count of entries
// (delete by value stops at the first equal entry), before they load the
// result register. A new beat is taken while a finished result still waits
// in the output register; the next operation then holds in its execute step
// until that result is taken. Entries above the count hold stale data and
// are never reported.
module ordered_array_list_engine_core
  import oal_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  oal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  oal_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // one operation in flight: an accepted beat blocks the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an operation is in flight");

  // failed operations report no maximum and no removed entry
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |->
      ((out_data.max_value == '0) && (out_data.removed_value == '0)))
    else $error("failed operation reports a value");

  // empty status only with no entries held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_EMPTY)) |-> (out_data.entry_count == '0))
    else $error("empty status with entries held");

  // full status only with every cell in use
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_FULL)) |->
      (out_data.entry_count == POS_W'(DEPTH)))
    else $error("full status below depth");

endmodule
